@@ design/lfupr_pkg.sv @@
// shared types and fixed widths for the lfu page replacement block
package lfupr_pkg;

   localparam int CFG_BITS         = 5;
   localparam int CFG_RESET        = 16;
   localparam int FRAME_INDEX_BITS = 4;
   localparam int LOAD_BITS        = 32;
   localparam int FAULT_BITS       = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

@@ design/lfupr_if.sv @@
// valid/ready channel interfaces for requests, responses and the csr write port
interface lfupr_req_if #(
   parameter int PAGE_BITS = 20
) ();
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

interface lfupr_rsp_if import lfupr_pkg::*; #(
   parameter int PAGE_BITS = 20
) ();
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [FRAME_INDEX_BITS-1:0] frame_index;
   logic                        evicted_valid;
   logic [PAGE_BITS-1:0]        evicted_page;
   logic [FAULT_BITS-1:0]       fault_count;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_count, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input fault_count, output ready);
endinterface

interface lfupr_csr_if import lfupr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/lfupr_frame_ram.sv @@
// single write port frame store with registered read
module lfupr_frame_ram #(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int WIDTH     = 68
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/lfu_page_replacement.sv @@
// lfu page replacement: one frame scanned per cycle through a shared compare unit
// steps: accept (frame 0 read), scan of the n active frames, update of the frame store
// requests wait for idle after the last update; one store read port paces the scan
// the response waits in an output register, so the next request may start meanwhile
// reset (synchronous, active high): all frames invalid, counters zero, 16 frames active
// no clearing pass: frame valid bits sit in flip-flops and reset clears them at once
module lfu_page_replacement import lfupr_pkg::*; #(
   parameter int FRAMES     = 16,
   parameter int PAGE_BITS  = 20,
   parameter int COUNT_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   lfupr_req_if.sink  req_chan,
   lfupr_rsp_if.source rsp_chan,
   lfupr_csr_if.sink  csr_chan
);

   localparam int IDX_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int N_BITS     = $clog2(FRAMES + 1);
   localparam int ENTRY_BITS = PAGE_BITS + COUNT_BITS + LOAD_BITS;

   // control state
   state_type           state_ff, state_in;
   logic [CFG_BITS-1:0] frames_in_use_ff, frames_in_use_in;
   logic [FRAMES-1:0]   valid_ff, valid_in;
   logic [LOAD_BITS-1:0]  ref_idx_ff, ref_idx_in;
   logic [FAULT_BITS-1:0] faults_ff, faults_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // scan bookkeeping
   logic [N_BITS-1:0]    n_ff, n_in;
   logic [N_BITS-1:0]    rd_idx_ff, rd_idx_in;
   logic [IDX_BITS-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [PAGE_BITS-1:0] pg_ff, pg_in;

   // hit tracker
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [LOAD_BITS-1:0]  hit_load_ff, hit_load_in;

   // victim tracker
   logic                  empty_ff, empty_in;
   logic                  have_ff, have_in;
   logic [IDX_BITS-1:0]   vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0] vic_cnt_ff, vic_cnt_in;
   logic [LOAD_BITS-1:0]  vic_load_ff, vic_load_in;
   logic [PAGE_BITS-1:0]  vic_page_ff, vic_page_in;

   // response register
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [FRAME_INDEX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic                        rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_BITS-1:0]        rsp_ev_page_ff, rsp_ev_page_in;
   logic [FAULT_BITS-1:0]       rsp_faults_ff, rsp_faults_in;

   // frame store port
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;

   logic [PAGE_BITS-1:0]  rd_page;
   logic [COUNT_BITS-1:0] rd_count;
   logic [LOAD_BITS-1:0]  rd_load;
   logic                  rd_frame_valid;
   logic [N_BITS-1:0]     n_eff;
   logic                  req_go;
   logic                  last_cmp;
   logic                  out_free;

   lfupr_frame_ram #(
      .DEPTH     (FRAMES),
      .ADDR_BITS (IDX_BITS),
      .WIDTH     (ENTRY_BITS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_page  = rd_data[ENTRY_BITS-1 -: PAGE_BITS];
   assign rd_count = rd_data[LOAD_BITS +: COUNT_BITS];
   assign rd_load  = rd_data[LOAD_BITS-1:0];
   assign rd_frame_valid = valid_ff[cmp_idx_ff];

   // zero acts as one frame, anything above the store acts as the whole store
   always_comb begin
      if (frames_in_use_ff == '0) begin
         n_eff = N_BITS'(1);
      end else if (32'(frames_in_use_ff) > 32'(FRAMES)) begin
         n_eff = N_BITS'(FRAMES);
      end else begin
         n_eff = N_BITS'(frames_in_use_ff);
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_go   = req_chan.valid && (state_ff == ST_IDLE);
   assign last_cmp = cmp_vld_ff && ((N_BITS'(cmp_idx_ff) + N_BITS'(1)) == n_ff);
   // output register can take a new response this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in         = state_ff;
      frames_in_use_in = frames_in_use_ff;
      valid_in         = valid_ff;
      ref_idx_in       = ref_idx_ff;
      faults_in        = faults_ff;
      cmp_vld_in       = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;

      n_in       = n_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      pg_in      = pg_ff;

      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      hit_cnt_in  = hit_cnt_ff;
      hit_load_in = hit_load_ff;
      empty_in    = empty_ff;
      have_in     = have_ff;
      vic_idx_in  = vic_idx_ff;
      vic_cnt_in  = vic_cnt_ff;
      vic_load_in = vic_load_ff;
      vic_page_in = vic_page_ff;

      rsp_hit_in      = rsp_hit_ff;
      rsp_idx_in      = rsp_idx_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_faults_in   = rsp_faults_ff;

      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_data = {pg_ff, hit_cnt_ff, hit_load_ff};
      rd_en   = 1'b0;
      rd_addr = rd_idx_ff[IDX_BITS-1:0];

      // csr writes land at once; the frame count is only sampled into n at accept
      if (csr_chan.valid) begin
         frames_in_use_in = csr_chan.data;
      end

      // shared compare unit: one frame per cycle, on the data read in the cycle before
      if (cmp_vld_ff) begin
         if (rd_frame_valid && (rd_page == pg_ff) && !found_ff) begin
            found_in    = 1'b1;
            hit_idx_in  = cmp_idx_ff;
            hit_cnt_in  = rd_count;
            hit_load_in = rd_load;
         end
         if (!rd_frame_valid) begin
            // first empty frame wins outright
            if (!empty_ff) begin
               empty_in   = 1'b1;
               have_in    = 1'b1;
               vic_idx_in = cmp_idx_ff;
            end
         end else if (!empty_ff && (!have_ff || (rd_count < vic_cnt_ff) ||
                      ((rd_count == vic_cnt_ff) && (rd_load < vic_load_ff)))) begin
            have_in     = 1'b1;
            vic_idx_in  = cmp_idx_ff;
            vic_cnt_in  = rd_count;
            vic_load_in = rd_load;
            vic_page_in = rd_page;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               // frame 0 is read in the accept cycle
               pg_in      = req_chan.page;
               n_in       = n_eff;
               rd_en      = 1'b1;
               rd_addr    = '0;
               rd_idx_in  = N_BITS'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = '0;
               found_in   = 1'b0;
               empty_in   = 1'b0;
               have_in    = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff < n_ff) begin
               rd_en      = 1'b1;
               rd_addr    = rd_idx_ff[IDX_BITS-1:0];
               rd_idx_in  = rd_idx_ff + N_BITS'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_BITS-1:0];
            end
            if (last_cmp) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               wr_en = 1'b1;
               if (found_ff) begin
                  // hit: bump use count, saturating
                  wr_addr = hit_idx_ff;
                  wr_data = {pg_ff,
                             (hit_cnt_ff == '1) ? hit_cnt_ff : hit_cnt_ff + COUNT_BITS'(1),
                             hit_load_ff};
                  rsp_idx_in      = FRAME_INDEX_BITS'(hit_idx_ff);
                  rsp_ev_valid_in = 1'b0;
                  rsp_ev_page_in  = '0;
                  rsp_faults_in   = faults_ff;
               end else begin
                  // fault: load the new page with count one and the current reference index
                  wr_addr = vic_idx_ff;
                  wr_data = {pg_ff, COUNT_BITS'(1), ref_idx_ff};
                  valid_in[vic_idx_ff] = 1'b1;
                  faults_in = (faults_ff == '1) ? faults_ff : faults_ff + FAULT_BITS'(1);
                  rsp_idx_in      = FRAME_INDEX_BITS'(vic_idx_ff);
                  rsp_ev_valid_in = !empty_ff;
                  rsp_ev_page_in  = empty_ff ? '0 : vic_page_ff;
                  rsp_faults_in   = faults_in;
               end
               rsp_hit_in   = found_ff;
               rsp_valid_in = 1'b1;
               ref_idx_in   = (ref_idx_ff == '1) ? ref_idx_ff : ref_idx_ff + LOAD_BITS'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         frames_in_use_ff <= CFG_BITS'(CFG_RESET);
         valid_ff         <= '0;
         ref_idx_ff       <= '0;
         faults_ff        <= '0;
         cmp_vld_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         frames_in_use_ff <= frames_in_use_in;
         valid_ff         <= valid_in;
         ref_idx_ff       <= ref_idx_in;
         faults_ff        <= faults_in;
         cmp_vld_ff       <= cmp_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, set up at accept before they are read
   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      rd_idx_ff       <= rd_idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      pg_ff           <= pg_in;
      found_ff        <= found_in;
      hit_idx_ff      <= hit_idx_in;
      hit_cnt_ff      <= hit_cnt_in;
      hit_load_ff     <= hit_load_in;
      empty_ff        <= empty_in;
      have_ff         <= have_in;
      vic_idx_ff      <= vic_idx_in;
      vic_cnt_ff      <= vic_cnt_in;
      vic_load_ff     <= vic_load_in;
      vic_page_ff     <= vic_page_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_idx_ff      <= rsp_idx_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_faults_ff   <= rsp_faults_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.frame_index   = rsp_idx_ff;
   assign rsp_chan.evicted_valid = rsp_ev_valid_ff;
   assign rsp_chan.evicted_page  = rsp_ev_page_ff;
   assign rsp_chan.fault_count   = rsp_faults_ff;

endmodule
